// ===== design/spa_pkg.sv =====
// ============================================================================
// spa_pkg
// Shared types, widths and codes of the sparse polynomial adder.
// ============================================================================
`default_nettype none

package spa_pkg;

    // Capacity of each term list
    localparam int TERMS_PER_LIST = 16;

    localparam int COEF_W = 32;
    localparam int EXP_W  = 16;
    localparam int TERM_W = COEF_W + EXP_W;
    localparam int FUNC_W = 2;

    // Count must hold TERMS_PER_LIST itself; index only addresses the entries
    localparam int CNT_W = $clog2(TERMS_PER_LIST + 1);
    localparam int IDX_W = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT,
        ST_EMPTY
    } spa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic step;
        logic emit_empty;
    } spa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic lists_empty;
        logic out_free;
        logic merge_last;
    } spa_status_t;

endpackage

`default_nettype wire

// ===== design/spa_if.sv =====
// ============================================================================
// spa_if
// Valid/ready channels for input terms and merged result terms.
// ============================================================================
`default_nettype none

interface spa_term_if;
    logic                                valid;
    logic                                ready;
    logic [spa_pkg::FUNC_W-1:0]          func;
    logic signed [spa_pkg::COEF_W-1:0]   coefficient;
    logic signed [spa_pkg::EXP_W-1:0]    exponent;

    modport source (output valid, output func, output coefficient, output exponent,
                    input ready);
    modport sink   (input valid, input func, input coefficient, input exponent,
                    output ready);
endinterface

interface spa_sum_if;
    logic                                valid;
    logic                                ready;
    logic signed [spa_pkg::COEF_W-1:0]   sum_coefficient;
    logic signed [spa_pkg::EXP_W-1:0]    sum_exponent;
    logic                                last_term;
    logic                                empty_sum;
    logic                                saturated;
    logic                                terms_lost;

    modport source (output valid, output sum_coefficient, output sum_exponent,
                    output last_term, output empty_sum, output saturated,
                    output terms_lost, input ready);
    modport sink   (input valid, input sum_coefficient, input sum_exponent,
                    input last_term, input empty_sum, input saturated,
                    input terms_lost, output ready);
endinterface

`default_nettype wire

// ===== design/sparse_polynomial_adder_core.sv =====
// Timing: after the start transfer each merged term goes through FETCH (registered
//   RAM read) and EMIT (compare/add into the result register); an empty result
//   goes through EMPTY. EMIT and EMPTY wait while an unaccepted result is held;
//   terms is ready again the cycle after the last term is stored.
// Reset: rst_n clears list counts, loss flag, pointers, state and result valid;
//   term stores are not cleared.
// ============================================================================
// sparse_polynomial_adder_core
// Merges two sparse polynomial term lists into their sum, highest exponent first.
// ============================================================================
`default_nettype none

module sparse_polynomial_adder_core (
    input  wire logic clk,
    input  wire logic rst_n,
    spa_term_if.sink  terms,
    spa_sum_if.source sums
);

    spa_pkg::spa_cmd_t    cmd;
    spa_pkg::spa_status_t status;

    // Controller: owns the input handshake and sequences each merge step.
    // Loads and the start transfer are taken only while idle; func codes outside
    // the defined set are accepted and dropped.
    spa_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (terms.valid),
        .func     (terms.func),
        .in_ready (terms.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: two term stores addressed by the list counts on load and by the
    // merge pointers on read. Each step compares the head exponents, adds equal
    // heads with saturation, advances one or both pointers and stores the term
    // in the result register. Hold the step while that register is occupied.
    spa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .coefficient     (terms.coefficient),
        .exponent        (terms.exponent),
        .out_valid       (sums.valid),
        .out_ready       (sums.ready),
        .sum_coefficient (sums.sum_coefficient),
        .sum_exponent    (sums.sum_exponent),
        .last_term       (sums.last_term),
        .empty_sum       (sums.empty_sum),
        .saturated       (sums.saturated),
        .terms_lost      (sums.terms_lost)
    );

`ifndef SYNTHESIS
    // An empty result always closes its merge
    assert property (@(posedge clk) disable iff (!rst_n)
        (sums.valid && sums.empty_sum) |-> sums.last_term)
        else $error("empty result without last_term");

    // An empty result carries zero coefficient, exponent and no saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (sums.valid && sums.empty_sum) |->
            (sums.sum_coefficient == '0 && sums.sum_exponent == '0 && !sums.saturated))
        else $error("empty result with nonzero fields");

    // A start transfer blocks further input until the merge is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (terms.valid && terms.ready && terms.func == spa_pkg::FUNC_START) |=> !terms.ready)
        else $error("input taken during merge");

    // A result is presented only after the controller has left idle
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(sums.valid)) |-> $past(!terms.ready))
        else $error("result appeared without a merge in progress");
`endif

endmodule

`default_nettype wire

// ===== design/spa_ram.sv =====
// ============================================================================
// spa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module spa_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/spa_datapath.sv =====
// ============================================================================
// spa_datapath
// Term stores, list counts, merge pointers, saturating adder, result register.
// ============================================================================
`default_nettype none

module spa_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire spa_pkg::spa_cmd_t                  cmd,
    output spa_pkg::spa_status_t                    status,
    input  wire logic signed [spa_pkg::COEF_W-1:0]  coefficient,
    input  wire logic signed [spa_pkg::EXP_W-1:0]   exponent,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [spa_pkg::COEF_W-1:0]       sum_coefficient,
    output logic signed [spa_pkg::EXP_W-1:0]        sum_exponent,
    output logic                                    last_term,
    output logic                                    empty_sum,
    output logic                                    saturated,
    output logic                                    terms_lost
);

    localparam int CW = spa_pkg::COEF_W;
    localparam int EW = spa_pkg::EXP_W;
    localparam int NW = spa_pkg::CNT_W;
    localparam int IW = spa_pkg::IDX_W;

    logic [NW-1:0] first_count_reg,  first_count_next;
    logic [NW-1:0] second_count_reg, second_count_next;
    logic          sticky_reg,       sticky_next;
    logic [NW-1:0] a_ptr_reg,        a_ptr_next;
    logic [NW-1:0] b_ptr_reg,        b_ptr_next;
    logic          out_valid_reg,    out_valid_next;

    logic signed [CW-1:0] coef_reg,  coef_next;
    logic signed [EW-1:0] exp_reg,   exp_next;
    logic                 last_reg,  last_next;
    logic                 empty_reg, empty_next;
    logic                 sat_reg,   sat_next;
    logic                 lost_reg,  lost_next;

    logic [spa_pkg::TERM_W-1:0] rd_first, rd_second;

    logic                 first_full, second_full;
    logic                 we_first, we_second;
    logic                 a_ok, b_ok, take_a, take_b;
    logic signed [CW-1:0] c1, c2;
    logic signed [EW-1:0] e1, e2;
    logic signed [CW:0]   sum_wide;
    logic                 sat_hi, sat_lo;
    logic signed [CW-1:0] merged_coef;
    logic                 merged_sat;
    logic [NW-1:0]        a_after, b_after;
    logic                 merge_last, finish;

    // ---- term stores -------------------------------------------------------
    assign first_full  = (first_count_reg  >= NW'(spa_pkg::TERMS_PER_LIST));
    assign second_full = (second_count_reg >= NW'(spa_pkg::TERMS_PER_LIST));
    assign we_first    = cmd.load_first  && !first_full;
    assign we_second   = cmd.load_second && !second_full;

    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::TERMS_PER_LIST)
    ) u_first_ram (
        .clk   (clk),
        .we    (we_first),
        .waddr (first_count_reg[IW-1:0]),
        .wdata ({exponent, coefficient}),
        .raddr (a_ptr_reg[IW-1:0]),
        .rdata (rd_first)
    );

    spa_ram #(
        .WIDTH (spa_pkg::TERM_W),
        .DEPTH (spa_pkg::TERMS_PER_LIST)
    ) u_second_ram (
        .clk   (clk),
        .we    (we_second),
        .waddr (second_count_reg[IW-1:0]),
        .wdata ({exponent, coefficient}),
        .raddr (b_ptr_reg[IW-1:0]),
        .rdata (rd_second)
    );

    // ---- merge step --------------------------------------------------------
    always_comb
    begin
        c1 = $signed(rd_first[CW-1:0]);
        e1 = $signed(rd_first[spa_pkg::TERM_W-1:CW]);
        c2 = $signed(rd_second[CW-1:0]);
        e2 = $signed(rd_second[spa_pkg::TERM_W-1:CW]);

        a_ok   = (a_ptr_reg < first_count_reg);
        b_ok   = (b_ptr_reg < second_count_reg);
        take_a = !b_ok || (a_ok && (e1 > e2));
        take_b = !take_a && (!a_ok || (e2 > e1));

        sum_wide = {c1[CW-1], c1} + {c2[CW-1], c2};
        sat_hi   = !sum_wide[CW] && sum_wide[CW-1];
        sat_lo   = sum_wide[CW] && !sum_wide[CW-1];

        if (take_a)
        begin
            merged_coef = c1;
            merged_sat  = 1'b0;
        end
        else if (take_b)
        begin
            merged_coef = c2;
            merged_sat  = 1'b0;
        end
        else if (sat_hi)
        begin
            merged_coef = {1'b0, {(CW-1){1'b1}}};
            merged_sat  = 1'b1;
        end
        else if (sat_lo)
        begin
            merged_coef = {1'b1, {(CW-1){1'b0}}};
            merged_sat  = 1'b1;
        end
        else
        begin
            merged_coef = sum_wide[CW-1:0];
            merged_sat  = 1'b0;
        end

        a_after    = a_ptr_reg + NW'(!take_b);
        b_after    = b_ptr_reg + NW'(!take_a);
        merge_last = (a_after >= first_count_reg) && (b_after >= second_count_reg);
    end

    assign finish = (cmd.step && merge_last) || cmd.emit_empty;

    // ---- control registers -------------------------------------------------
    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        sticky_next       = sticky_reg;
        if (finish)
        begin
            first_count_next  = '0;
            second_count_next = '0;
            sticky_next       = 1'b0;
        end
        else
        begin
            if (we_first)
            begin
                first_count_next = first_count_reg + NW'(1);
            end
            if (we_second)
            begin
                second_count_next = second_count_reg + NW'(1);
            end
            if ((cmd.load_first && first_full) || (cmd.load_second && second_full))
            begin
                sticky_next = 1'b1;
            end
        end

        a_ptr_next = a_ptr_reg;
        b_ptr_next = b_ptr_reg;
        if (cmd.start)
        begin
            a_ptr_next = '0;
            b_ptr_next = '0;
        end
        else if (cmd.step)
        begin
            a_ptr_next = a_after;
            b_ptr_next = b_after;
        end

        if (cmd.step || cmd.emit_empty)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ---- result payload ----------------------------------------------------
    always_comb
    begin
        coef_next  = coef_reg;
        exp_next   = exp_reg;
        last_next  = last_reg;
        empty_next = empty_reg;
        sat_next   = sat_reg;
        lost_next  = lost_reg;
        if (cmd.step)
        begin
            coef_next  = merged_coef;
            exp_next   = take_b ? e2 : e1;
            last_next  = merge_last;
            empty_next = 1'b0;
            sat_next   = merged_sat;
            lost_next  = sticky_reg;
        end
        else if (cmd.emit_empty)
        begin
            coef_next  = '0;
            exp_next   = '0;
            last_next  = 1'b1;
            empty_next = 1'b1;
            sat_next   = 1'b0;
            lost_next  = sticky_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            sticky_reg       <= 1'b0;
            a_ptr_reg        <= '0;
            b_ptr_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            sticky_reg       <= sticky_next;
            a_ptr_reg        <= a_ptr_next;
            b_ptr_reg        <= b_ptr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg  <= coef_next;
        exp_reg   <= exp_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        sat_reg   <= sat_next;
        lost_reg  <= lost_next;
    end

    assign status.lists_empty = (first_count_reg == '0) && (second_count_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.merge_last  = merge_last;

    assign out_valid       = out_valid_reg;
    assign sum_coefficient = coef_reg;
    assign sum_exponent    = exp_reg;
    assign last_term       = last_reg;
    assign empty_sum       = empty_reg;
    assign saturated       = sat_reg;
    assign terms_lost      = lost_reg;

endmodule

`default_nettype wire

// ===== design/spa_controller.sv =====
// ============================================================================
// spa_controller
// Sequencer for loads and the fetch/emit walk of a merge.
// ============================================================================
`default_nettype none

module spa_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [spa_pkg::FUNC_W-1:0]  func,
    output logic                             in_ready,
    input  wire spa_pkg::spa_status_t        status,
    output spa_pkg::spa_cmd_t                cmd
);

    spa_pkg::spa_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                if (in_valid && (func == spa_pkg::FUNC_START))
                begin
                    state_next = status.lists_empty ? spa_pkg::ST_EMPTY : spa_pkg::ST_FETCH;
                end
            end
            spa_pkg::ST_FETCH:
            begin
                state_next = spa_pkg::ST_EMIT;
            end
            spa_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.merge_last ? spa_pkg::ST_IDLE : spa_pkg::ST_FETCH;
                end
            end
            spa_pkg::ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    state_next = spa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd.load_first  = 1'b0;
        cmd.load_second = 1'b0;
        cmd.start       = 1'b0;
        cmd.step        = 1'b0;
        cmd.emit_empty  = 1'b0;
        case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.load_first  = in_valid && (func == spa_pkg::FUNC_LOAD_FIRST);
                cmd.load_second = in_valid && (func == spa_pkg::FUNC_LOAD_SECOND);
                cmd.start       = in_valid && (func == spa_pkg::FUNC_START);
            end
            spa_pkg::ST_EMIT:
            begin
                cmd.step = status.out_free;
            end
            spa_pkg::ST_EMPTY:
            begin
                cmd.emit_empty = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== test/poly_sum_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// poly_sum_checker
// Watches the term and sum channels, keeps its own copy of both term lists,
// predicts every merged term and compares each sum transfer in order.
// ============================================================================

module poly_sum_checker
    import spa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spa_term_if  terms,
    spa_sum_if   sums,
    output int   fail_count,
    output int   pending_terms
);

    typedef struct {
        logic signed [COEF_W-1:0] sum_coefficient;
        logic signed [EXP_W-1:0]  sum_exponent;
        logic                     last_term;
        logic                     empty_sum;
        logic                     saturated;
        logic                     terms_lost;
    } merged_term_t;

    localparam int REPORT_LIMIT = 10;

    logic signed [COEF_W-1:0] first_coef [TERMS_PER_LIST];
    logic signed [EXP_W-1:0]  first_exp  [TERMS_PER_LIST];
    logic signed [COEF_W-1:0] second_coef[TERMS_PER_LIST];
    logic signed [EXP_W-1:0]  second_exp [TERMS_PER_LIST];
    int                       first_len;
    int                       second_len;
    logic                     lost_flag;
    merged_term_t             expected_terms[$];
    int                       reports;

    // Walk both lists head to head and queue the merged terms
    task automatic predict_merge();
        int           a;
        int           b;
        logic [COEF_W:0] wide;
        merged_term_t t;
        a = 0;
        b = 0;
        if (first_len == 0 && second_len == 0) begin
            t.sum_coefficient = '0;
            t.sum_exponent    = '0;
            t.last_term       = 1'b1;
            t.empty_sum       = 1'b1;
            t.saturated       = 1'b0;
            t.terms_lost      = lost_flag;
            expected_terms.push_back(t);
        end
        else begin
            while (a < first_len || b < second_len) begin
                t.empty_sum  = 1'b0;
                t.saturated  = 1'b0;
                t.terms_lost = lost_flag;
                if (b >= second_len || (a < first_len && first_exp[a] > second_exp[b])) begin
                    t.sum_coefficient = first_coef[a];
                    t.sum_exponent    = first_exp[a];
                    a++;
                end
                else if (a >= first_len || second_exp[b] > first_exp[a]) begin
                    t.sum_coefficient = second_coef[b];
                    t.sum_exponent    = second_exp[b];
                    b++;
                end
                else begin
                    // equal heads: add with one guard bit, clamp on overflow
                    wide = {first_coef[a][COEF_W-1], first_coef[a]}
                         + {second_coef[b][COEF_W-1], second_coef[b]};
                    if (wide[COEF_W] == wide[COEF_W-1]) begin
                        t.sum_coefficient = wide[COEF_W-1:0];
                    end
                    else begin
                        t.saturated       = 1'b1;
                        t.sum_coefficient = wide[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                                         : {1'b0, {(COEF_W-1){1'b1}}};
                    end
                    t.sum_exponent = first_exp[a];
                    a++;
                    b++;
                end
                t.last_term = (a >= first_len && b >= second_len);
                expected_terms.push_back(t);
            end
        end
        first_len  = 0;
        second_len = 0;
        lost_flag  = 1'b0;
    endtask

    task automatic take_term();
        case (terms.func)
            FUNC_LOAD_FIRST: begin
                if (first_len >= TERMS_PER_LIST) begin
                    lost_flag = 1'b1;
                end
                else begin
                    first_coef[first_len] = terms.coefficient;
                    first_exp[first_len]  = terms.exponent;
                    first_len++;
                end
            end
            FUNC_LOAD_SECOND: begin
                if (second_len >= TERMS_PER_LIST) begin
                    lost_flag = 1'b1;
                end
                else begin
                    second_coef[second_len] = terms.coefficient;
                    second_exp[second_len]  = terms.exponent;
                    second_len++;
                end
            end
            FUNC_START: predict_merge();
            default: ;
        endcase
    endtask

    task automatic check_sum();
        merged_term_t t;
        if (expected_terms.size() == 0) begin
            fail_count++;
            if (reports < REPORT_LIMIT) begin
                reports++;
                $display("[checker] %0t unexpected sum: coef=%h exp=%h last=%b empty=%b",
                         $realtime, sums.sum_coefficient, sums.sum_exponent,
                         sums.last_term, sums.empty_sum);
            end
        end
        else begin
            t = expected_terms.pop_front();
            if (sums.sum_coefficient !== t.sum_coefficient
                || sums.sum_exponent !== t.sum_exponent
                || sums.last_term !== t.last_term
                || sums.empty_sum !== t.empty_sum
                || sums.saturated !== t.saturated
                || sums.terms_lost !== t.terms_lost) begin
                fail_count++;
                if (reports < REPORT_LIMIT) begin
                    reports++;
                    $display("[checker] %0t mismatch: expected coef=%h exp=%h last=%b empty=%b sat=%b lost=%b",
                             $realtime, t.sum_coefficient, t.sum_exponent, t.last_term,
                             t.empty_sum, t.saturated, t.terms_lost);
                    $display("[checker]           actual coef=%h exp=%h last=%b empty=%b sat=%b lost=%b",
                             sums.sum_coefficient, sums.sum_exponent, sums.last_term,
                             sums.empty_sum, sums.saturated, sums.terms_lost);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            first_len     = 0;
            second_len    = 0;
            lost_flag     = 1'b0;
            reports       = 0;
            fail_count    = 0;
            expected_terms.delete();
            pending_terms = 0;
        end
        else begin
            if (sums.valid && sums.ready) begin
                check_sum();
            end
            if (terms.valid && terms.ready) begin
                take_term();
            end
            pending_terms = expected_terms.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Drives load and start transfers into the sparse polynomial adder under
// random idling on both channels and reports the verdict of the checker.
// ============================================================================

module tb_top;
    import spa_pkg::*;

    // Selector code the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int ITEM_TARGET   = 270;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int TAIL_CYCLES   = 20;

    logic clk = 1'b0;
    logic rst_n;

    int src_idle_pct;
    int sink_idle_pct;
    int items_sent;
    int fail_count;
    int pending_terms;
    int quiet_cycles;

    spa_term_if terms_ch();
    spa_sum_if  sums_ch();

    sparse_polynomial_adder_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .terms (terms_ch),
        .sums  (sums_ch)
    );

    poly_sum_checker u_sum_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .terms         (terms_ch),
        .sums          (sums_ch),
        .fail_count    (fail_count),
        .pending_terms (pending_terms)
    );

    always #5 clk = ~clk;

    // Receiver side: drop ready at random, re-decided at every falling edge
    initial
    begin
        sums_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            sums_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (terms_ch.valid && terms_ch.ready) || (sums_ch.valid && sums_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("[watchdog] no transfer for %0d cycles", WATCHDOG_MAX);
            $display("[sparse_polynomial_adder_core] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one term, idle at random first, hold it until the transfer.
    // Called and returns at a falling edge; valid stays high on return so a
    // back-to-back item sees no gap.
    task automatic send_term(input logic [FUNC_W-1:0] f, input logic [COEF_W-1:0] c,
                             input logic [EXP_W-1:0] e);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            terms_ch.valid <= 1'b0;
            @(negedge clk);
        end
        terms_ch.valid       <= 1'b1;
        terms_ch.func        <= f;
        terms_ch.coefficient <= c;
        terms_ch.exponent    <= e;
        @(posedge clk);
        while (!terms_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (f != FUNC_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Hold off the sender until every predicted sum has been received
    task automatic drain_sums();
        terms_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_terms != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        else if (r < 6)
        begin
            return $urandom;
        end
        return $urandom_range(0, 1) ? $urandom_range(0, 32'h003F_FFFF)
                                    : -$urandom_range(0, 32'h003F_FFFF);
    endfunction

    function automatic int clamp_exp(input int e);
        if (e > 32767)
        begin
            return 32767;
        end
        if (e < -32768)
        begin
            return -32768;
        end
        return e;
    endfunction

    // One merge: load both lists in random interleave, then start.
    // Mostly sorted lists with shared exponents; some overfill a list, some
    // are unsorted and a few carry ignored selectors and scattered exponents.
    task automatic run_merge();
        int kind;
        int n1;
        int n2;
        int i1;
        int i2;
        int e1;
        int e2;
        int top_e;
        int tmp;
        bit take_first;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            n1 = 16 + $urandom_range(0, 3);
            n2 = $urandom_range(0, 16);
            if ($urandom_range(0, 1))
            begin
                tmp = n1;
                n1  = n2;
                n2  = tmp;
            end
        end
        else if (kind < 14)
        begin
            n1 = 16;
            n2 = 16;
        end
        else
        begin
            n1 = $urandom_range(0, 6);
            n2 = $urandom_range(0, 6);
        end
        top_e = ($urandom_range(0, 7) == 0) ? 32767 : int'($urandom_range(0, 65535)) - 32768;
        if (top_e < -32768 + 64)
        begin
            top_e = -32768 + 64;
        end
        e1 = top_e;
        e2 = top_e - $urandom_range(0, 1);
        i1 = 0;
        i2 = 0;
        while (i1 < n1 || i2 < n2)
        begin
            if (kind >= 90 && $urandom_range(0, 3) == 0)
            begin
                send_term(FUNC_UNUSED, $urandom, $urandom);
            end
            take_first = (i2 >= n2) || (i1 < n1 && $urandom_range(0, 1));
            if (kind >= 90)
            begin
                send_term(take_first ? FUNC_LOAD_FIRST : FUNC_LOAD_SECOND, $urandom, $urandom);
            end
            else if (take_first)
            begin
                send_term(FUNC_LOAD_FIRST, pick_coef(), e1[EXP_W-1:0]);
                e1 = clamp_exp(e1 - ((kind >= 80) ? $urandom_range(0, 3) - 1
                                                  : $urandom_range(1, 3)));
            end
            else
            begin
                send_term(FUNC_LOAD_SECOND, pick_coef(), e2[EXP_W-1:0]);
                e2 = clamp_exp(e2 - ((kind >= 80) ? $urandom_range(0, 3) - 1
                                                  : $urandom_range(1, 3)));
            end
            if (take_first)
            begin
                i1++;
            end
            else
            begin
                i2++;
            end
        end
        send_term(FUNC_START, $urandom, $urandom);
    endtask

    initial
    begin
        int phase;
        terms_ch.valid       = 1'b0;
        terms_ch.func        = FUNC_LOAD_FIRST;
        terms_ch.coefficient = '0;
        terms_ch.exponent    = '0;
        rst_n                = 1'b0;
        src_idle_pct         = 12;
        sink_idle_pct        = 68;
        items_sent           = 0;
        phase                = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Both lists empty: one empty-sum result
        send_term(FUNC_START, 32'h1234_5678, 16'h00AA);

        // Saturate high, cancel to zero, lone term, saturate low at the extremes
        send_term(FUNC_LOAD_FIRST,  32'h7FFF_FFFF, 16'sd32767);
        send_term(FUNC_LOAD_SECOND, 32'h7FFF_FFFF, 16'sd32767);
        send_term(FUNC_LOAD_FIRST,  32'h0001_0000, 16'sd5);
        send_term(FUNC_LOAD_SECOND, 32'hFFFF_0000, 16'sd5);
        send_term(FUNC_UNUSED,      32'hFFFF_FFFF, 16'hFFFF);
        send_term(FUNC_LOAD_SECOND, 32'h0001_2345, 16'sd3);
        send_term(FUNC_LOAD_FIRST,  32'h8000_0000, -16'sd32768);
        send_term(FUNC_LOAD_SECOND, 32'h8000_0000, -16'sd32768);
        send_term(FUNC_START,       32'h0,         16'h0);

        // Unsorted first list with a repeated exponent against one term
        send_term(FUNC_LOAD_FIRST,  32'h0000_0001, 16'sd2);
        send_term(FUNC_LOAD_FIRST,  32'h0000_0002, 16'sd2);
        send_term(FUNC_LOAD_FIRST,  32'h0000_0003, 16'sd9);
        send_term(FUNC_LOAD_SECOND, 32'h0000_0004, 16'sd5);
        send_term(FUNC_START,       32'h0,         16'h0);

        // Second list alone
        send_term(FUNC_LOAD_SECOND, 32'hFFFF_FFFB, 16'sd0);
        send_term(FUNC_START,       32'h0,         16'h0);

        // Random merges; switch idling at each third, draining first
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 0 && items_sent >= ITEM_TARGET / 3)
            begin
                drain_sums();
                src_idle_pct  = 68;
                sink_idle_pct = 12;
                phase         = 1;
            end
            else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3)
            begin
                drain_sums();
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                phase         = 2;
            end
            run_merge();
        end

        drain_sums();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_terms == 0)
        begin
            $display("[sparse_polynomial_adder_core] OK");
        end
        else
        begin
            $display("[sparse_polynomial_adder_core] ERROR");
        end
        $finish;
    end

endmodule
